// File: sv/assert_macros.svh
// assertion macros shared by the heap sort engine modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/hse_pkg.sv
// shared types and constants of the heap sort engine
package hse_pkg;

	localparam int MAX_ITEMS_DEF = 64;
	localparam int DATA_W        = 32;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_B_NEXT,
		ST_LD_CUR,
		ST_STEP,
		ST_LC,
		ST_RC,
		ST_DEC,
		ST_X_NEXT,
		ST_X_LD_LAST,
		ST_X_LD_ROOT,
		ST_E_RD,
		ST_E_CAP,
		ST_E_HOLD
	} state_t;

	typedef enum logic [3:0] {
		OP_LOAD,
		OP_B_NEXT,
		OP_LD_CUR,
		OP_STEP,
		OP_LC,
		OP_RC,
		OP_DEC,
		OP_X_NEXT,
		OP_X_LD_LAST,
		OP_X_LD_ROOT,
		OP_E_RD,
		OP_E_CAP,
		OP_E_HOLD
	} op_t;

	typedef struct packed {
		op_t  op;
		logic fire;
	} cmd_t;

	typedef struct packed {
		logic k_zero;
		logic k_le1;
		logic lc_out;
		logic rc_in;
		logic big_is_root;
		logic out_last;
	} status_t;

endpackage

// File: sv/hse_ctrl.sv
// sequencer of the heap sort engine: load, heap build, extraction and emission
`include "assert_macros.svh"

module hse_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tlast,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output hse_pkg::cmd_t    cmd,
	input  hse_pkg::status_t st
);

	hse_pkg::state_t state_q, state_d;
	logic            phase_q, phase_d;
	hse_pkg::state_t ret_state;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hse_pkg::ST_LOAD;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	// phase 0 is heap build, phase 1 is extraction
	assign ret_state = phase_q ? hse_pkg::ST_X_NEXT : hse_pkg::ST_B_NEXT;

	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		cmd.op   = hse_pkg::OP_LOAD;
		cmd.fire = 1'b0;
		case (state_q)
			hse_pkg::ST_LOAD: begin
				s_tready = 1'b1;
				cmd.op   = hse_pkg::OP_LOAD;
				cmd.fire = s_tvalid;
				phase_d  = 1'b0;
				if (s_tvalid && s_tlast) begin
					state_d = hse_pkg::ST_B_NEXT;
				end
			end
			hse_pkg::ST_B_NEXT: begin
				cmd.op = hse_pkg::OP_B_NEXT;
				if (st.k_zero) begin
					state_d = hse_pkg::ST_X_NEXT;
					phase_d = 1'b1;
				end else begin
					state_d = hse_pkg::ST_LD_CUR;
				end
			end
			hse_pkg::ST_LD_CUR: begin
				cmd.op  = hse_pkg::OP_LD_CUR;
				state_d = hse_pkg::ST_STEP;
			end
			hse_pkg::ST_STEP: begin
				cmd.op  = hse_pkg::OP_STEP;
				state_d = st.lc_out ? ret_state : hse_pkg::ST_LC;
			end
			hse_pkg::ST_LC: begin
				cmd.op  = hse_pkg::OP_LC;
				state_d = st.rc_in ? hse_pkg::ST_RC : hse_pkg::ST_DEC;
			end
			hse_pkg::ST_RC: begin
				cmd.op  = hse_pkg::OP_RC;
				state_d = hse_pkg::ST_DEC;
			end
			hse_pkg::ST_DEC: begin
				cmd.op  = hse_pkg::OP_DEC;
				state_d = st.big_is_root ? ret_state : hse_pkg::ST_STEP;
			end
			hse_pkg::ST_X_NEXT: begin
				cmd.op  = hse_pkg::OP_X_NEXT;
				state_d = st.k_le1 ? hse_pkg::ST_E_RD : hse_pkg::ST_X_LD_LAST;
			end
			hse_pkg::ST_X_LD_LAST: begin
				cmd.op  = hse_pkg::OP_X_LD_LAST;
				state_d = hse_pkg::ST_X_LD_ROOT;
			end
			hse_pkg::ST_X_LD_ROOT: begin
				cmd.op  = hse_pkg::OP_X_LD_ROOT;
				state_d = hse_pkg::ST_STEP;
			end
			hse_pkg::ST_E_RD: begin
				cmd.op  = hse_pkg::OP_E_RD;
				state_d = hse_pkg::ST_E_CAP;
			end
			hse_pkg::ST_E_CAP: begin
				cmd.op  = hse_pkg::OP_E_CAP;
				state_d = hse_pkg::ST_E_HOLD;
			end
			hse_pkg::ST_E_HOLD: begin
				m_tvalid = 1'b1;
				cmd.op   = hse_pkg::OP_E_HOLD;
				cmd.fire = m_tready;
				if (m_tready) begin
					state_d = st.out_last ? hse_pkg::ST_LOAD : hse_pkg::ST_E_RD;
				end
			end
			default: begin
				state_d = hse_pkg::ST_LOAD;
			end
		endcase
	end

	`ASSERT_ALWAYS(a_no_in_during_out, !(s_tready && m_tvalid), "input open while result pending")
	`ASSERT_CLK(a_last_leaves_load, (s_tvalid && s_tready) |=> (state_q == hse_pkg::ST_LOAD ||
		state_q == hse_pkg::ST_B_NEXT), "unexpected state after request")

endmodule

// File: sv/hse_dp.sv
// datapath of the heap sort engine: element store, counters and sift compare
`include "assert_macros.svh"

module hse_dp #(
	parameter int MAX_ITEMS = hse_pkg::MAX_ITEMS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  hse_pkg::cmd_t                     cmd,
	output hse_pkg::status_t                  st,
	input  logic signed [hse_pkg::DATA_W-1:0] in_value,
	input  logic                              in_last,
	output logic signed [hse_pkg::DATA_W-1:0] out_value,
	output logic                              out_last,
	output logic                              out_ovf
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int IW = AW + 2;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);

	logic signed [hse_pkg::DATA_W-1:0] mem_q [MAX_ITEMS];
	logic signed [hse_pkg::DATA_W-1:0] rdata_q;
	logic signed [hse_pkg::DATA_W-1:0] cur_q, bv_q;
	logic signed [hse_pkg::DATA_W-1:0] out_val_q;
	logic                              out_last_q, out_ovf_q;

	logic [CW-1:0] count_q, size_q, heap_q, k_q;
	logic [AW-1:0] root_q, big_q;
	logic          ovf_q;

	logic                              we;
	logic [AW-1:0]                     waddr, raddr;
	logic signed [hse_pkg::DATA_W-1:0] wdata;

	logic [IW-1:0] lc_w, rc_w, heap_w;
	logic [CW-1:0] k_m1, n_next, k_p1;
	logic          has_room;

	assign lc_w     = {1'b0, root_q, 1'b1};
	assign rc_w     = lc_w + IW'(1);
	assign heap_w   = IW'(heap_q);
	assign k_m1     = k_q - CW'(1);
	assign k_p1     = k_q + CW'(1);
	assign has_room = count_q < MAX_C;
	assign n_next   = has_room ? count_q + CW'(1) : count_q;

	assign st.k_zero      = k_q == '0;
	assign st.k_le1       = k_q <= CW'(1);
	assign st.lc_out      = lc_w >= heap_w;
	assign st.rc_in       = rc_w < heap_w;
	assign st.big_is_root = big_q == root_q;
	assign st.out_last    = out_last_q;

	assign out_value = out_val_q;
	assign out_last  = out_last_q;
	assign out_ovf   = out_ovf_q;

	always_comb begin
		we    = 1'b0;
		waddr = root_q;
		wdata = cur_q;
		raddr = '0;
		case (cmd.op)
			hse_pkg::OP_LOAD: begin
				we    = cmd.fire && has_room;
				waddr = count_q[AW-1:0];
				wdata = in_value;
			end
			hse_pkg::OP_B_NEXT:   raddr = k_m1[AW-1:0];
			hse_pkg::OP_STEP: begin
				we    = st.lc_out;
				raddr = lc_w[AW-1:0];
			end
			hse_pkg::OP_LC:       raddr = rc_w[AW-1:0];
			hse_pkg::OP_DEC: begin
				we    = 1'b1;
				wdata = st.big_is_root ? cur_q : bv_q;
			end
			hse_pkg::OP_X_NEXT:   raddr = k_m1[AW-1:0];
			hse_pkg::OP_X_LD_ROOT: begin
				we    = 1'b1;
				waddr = k_m1[AW-1:0];
				wdata = rdata_q;
			end
			hse_pkg::OP_E_RD:     raddr = k_q[AW-1:0];
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			size_q  <= '0;
			heap_q  <= '0;
			k_q     <= '0;
			root_q  <= '0;
			big_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			case (cmd.op)
				hse_pkg::OP_LOAD: begin
					if (cmd.fire) begin
						count_q <= n_next;
						if (!has_room) begin
							ovf_q <= 1'b1;
						end
						if (in_last) begin
							size_q <= n_next;
							heap_q <= n_next;
							k_q    <= n_next >> 1;
						end
					end
				end
				hse_pkg::OP_B_NEXT: begin
					if (st.k_zero) begin
						k_q <= size_q;
					end else begin
						k_q    <= k_m1;
						root_q <= k_m1[AW-1:0];
					end
				end
				hse_pkg::OP_LC: begin
					big_q <= (rdata_q > cur_q) ? lc_w[AW-1:0] : root_q;
				end
				hse_pkg::OP_RC: begin
					if (rdata_q > bv_q) begin
						big_q <= rc_w[AW-1:0];
					end
				end
				hse_pkg::OP_DEC: begin
					root_q <= big_q;
				end
				hse_pkg::OP_X_NEXT: begin
					if (st.k_le1) begin
						k_q <= '0;
					end
				end
				hse_pkg::OP_X_LD_ROOT: begin
					heap_q <= k_m1;
					k_q    <= k_m1;
					root_q <= '0;
				end
				hse_pkg::OP_E_HOLD: begin
					if (cmd.fire) begin
						if (out_last_q) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
						end else begin
							k_q <= k_p1;
						end
					end
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

	// sift value, best child value and result payload
	always_ff @(posedge clk) begin
		case (cmd.op)
			hse_pkg::OP_LD_CUR:    cur_q <= rdata_q;
			hse_pkg::OP_X_LD_LAST: cur_q <= rdata_q;
			hse_pkg::OP_LC:        bv_q  <= (rdata_q > cur_q) ? rdata_q : cur_q;
			hse_pkg::OP_RC: begin
				if (rdata_q > bv_q) begin
					bv_q <= rdata_q;
				end
			end
			hse_pkg::OP_E_CAP: begin
				out_val_q  <= rdata_q;
				out_last_q <= k_p1 == size_q;
				out_ovf_q  <= ovf_q;
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	`ASSERT_CLK(a_count_bound, count_q <= MAX_C, "element count beyond capacity")
	`ASSERT_CLK(a_heap_bound, heap_q <= size_q, "heap larger than run")
	`ASSERT_CLK(a_run_clears, (cmd.op == hse_pkg::OP_E_HOLD && cmd.fire && out_last_q) |=>
		(count_q == '0 && !ovf_q), "run state not cleared after final result")

endmodule

// File: sv/heap_sort_engine_core.sv
// heap sort engine: collects a set, heap sorts it in place, emits it ascending
// loading accepts an item whenever s_tvalid is high; the item marked last starts the sort
// each sift level runs STEP, LC, an optional RC and DEC on the single read port of the store
// build is size/2 sifts, extraction size-1 sifts of up to log2(size) levels each
// emission runs E_RD, E_CAP and E_HOLD per result, waiting in E_HOLD on sink stalls; no input during sort or emission
// reset clears counters, the overflow flag and sequencer; store contents stay undefined, no clearing pass

module heap_sort_engine_core #(
	parameter int MAX_ITEMS = hse_pkg::MAX_ITEMS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic signed [hse_pkg::DATA_W-1:0] s_tdata,  // value
	input  logic                              s_tlast,  // last
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic signed [hse_pkg::DATA_W-1:0] m_tdata,  // sorted_value
	output logic                              m_tlast,  // last_of_run
	output logic                              m_tuser   // overflowed
);

	hse_pkg::cmd_t    cmd;
	hse_pkg::status_t st;

	hse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.st       (st)
	);

	hse_dp #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_value  (s_tdata),
		.in_last   (s_tlast),
		.out_value (m_tdata),
		.out_last  (m_tlast),
		.out_ovf   (m_tuser)
	);

endmodule
